/* sv/nearest_palette_color_search_unit_assert.svh */
// Assertion macros for the nearest palette colour search unit.
// Expects signals named clk and rst_n in the including module.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NPCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define NPCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/npcs_pkg.sv */
// Shared types and constants for the nearest palette colour search unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
  localparam logic [PAL_IDX_W-1:0] PAL_LAST = PAL_IDX_W'(PAL_ENTRIES - 1);

  localparam int CH_W    = 8;
  localparam int ENTRY_W = 3 * CH_W;
  localparam int SQ_W    = 2 * CH_W;
  localparam int DIST_W  = 18;
  localparam int COLOR_W = 15;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } npcs_op_t;

  typedef struct packed {
    logic                 load_we;
    logic                 start;
    logic                 issue;
    logic                 issue_last;
    logic [PAL_IDX_W-1:0] issue_addr;
    logic                 publish;
  } npcs_cmd_t;

  typedef struct packed {
    logic last_done;
  } npcs_stat_t;

endpackage

`default_nettype wire

/* sv/npcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/npcs_dp.sv */
// Datapath: palette RAM, entry valid bits, distance pipeline, best tracker.
// Depends on npcs_pkg, npcs_ram and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_palette_color_search_unit_assert.svh"

module npcs_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire npcs_pkg::npcs_cmd_t        cmd,
  output npcs_pkg::npcs_stat_t            stat,
  input  wire logic [7:0]                 entry_index,
  input  wire logic [7:0]                 red,
  input  wire logic [7:0]                 green,
  input  wire logic [7:0]                 blue,
  input  wire logic [14:0]                color_in,
  output logic      [7:0]                 nearest_index,
  output logic      [npcs_pkg::DIST_W-1:0] best_distance_sq
);
  import npcs_pkg::*;

  logic [PAL_ENTRIES-1:0] valid_r;
  logic [ENTRY_W-1:0]     rdata;

  logic [CH_W-1:0] qr_r, qg_r, qb_r;

  logic                 s1_vld_r, s1_last_r, s1_first_r, s1_hit_r;
  logic [PAL_IDX_W-1:0] s1_idx_r;
  logic                 s2_vld_r, s2_last_r, s2_first_r;
  logic [PAL_IDX_W-1:0] s2_idx_r;
  logic [SQ_W-1:0]      sqr_r, sqg_r, sqb_r;

  logic [PAL_IDX_W-1:0] best_idx_r;
  logic [DIST_W-1:0]    best_d_r;
  logic [7:0]           out_idx_r;
  logic [DIST_W-1:0]    out_d_r;

  logic [ENTRY_W-1:0] entry;
  logic [CH_W-1:0]    dr, dg, db;
  logic [DIST_W-1:0]  dist_sum;
  logic               take;

  npcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAL_ENTRIES)
  ) u_pal (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (entry_index[PAL_IDX_W-1:0]),
    .wdata ({blue, green, red}),
    .re    (cmd.issue),
    .raddr (cmd.issue_addr),
    .rdata (rdata)
  );

  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // never-written entries read as black
  assign entry = s1_hit_r ? rdata : '0;
  assign dr    = absdiff(qr_r, entry[CH_W-1:0]);
  assign dg    = absdiff(qg_r, entry[2*CH_W-1:CH_W]);
  assign db    = absdiff(qb_r, entry[3*CH_W-1:2*CH_W]);

  assign dist_sum = DIST_W'(sqr_r) + DIST_W'(sqg_r) + DIST_W'(sqb_r);
  assign take     = s2_vld_r && (s2_first_r || (dist_sum < best_d_r));

  assign stat.last_done = s2_vld_r && s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (cmd.load_we) begin
        valid_r[entry_index[PAL_IDX_W-1:0]] <= 1'b1;
      end
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qr_r <= {color_in[4:0], 3'd4};
      qg_r <= {color_in[9:5], 3'd4};
      qb_r <= {color_in[14:10], 3'd4};
    end
    s1_last_r  <= cmd.issue_last;
    s1_first_r <= (cmd.issue_addr == '0);
    s1_idx_r   <= cmd.issue_addr;
    s1_hit_r   <= valid_r[cmd.issue_addr];

    s2_last_r  <= s1_last_r;
    s2_first_r <= s1_first_r;
    s2_idx_r   <= s1_idx_r;
    sqr_r      <= SQ_W'(dr) * SQ_W'(dr);
    sqg_r      <= SQ_W'(dg) * SQ_W'(dg);
    sqb_r      <= SQ_W'(db) * SQ_W'(db);

    if (take) begin
      best_idx_r <= s2_idx_r;
      best_d_r   <= dist_sum;
    end
    if (cmd.publish) begin
      out_idx_r <= 8'(best_idx_r);
      out_d_r   <= best_d_r;
    end
  end

  assign nearest_index    = out_idx_r;
  assign best_distance_sq = out_d_r;

  `NPCS_ASSERT_IMP(a_no_load_in_scan, cmd.load_we, !s1_vld_r && !s2_vld_r, "load during scan")
  `NPCS_ASSERT_IMP(a_no_publish_in_scan, cmd.publish, !s1_vld_r && !s2_vld_r,
                   "publish while pipeline busy")

endmodule

`default_nettype wire

/* sv/npcs_ctrl.sv */
// Controller FSM: accepts items, sequences the palette scan, owns result valid.
// Depends on npcs_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_palette_color_search_unit_assert.svh"

module npcs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic                 in_tuser,
  input  wire logic [7:0]           entry_index,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output npcs_pkg::npcs_cmd_t       cmd,
  input  wire npcs_pkg::npcs_stat_t stat
);
  import npcs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PUB
  } state_t;

  state_t               state_r, state_nxt;
  logic [PAL_IDX_W-1:0] addr_r, addr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.issue_addr = addr_r;
    cmd.issue_last = (addr_r == PAL_LAST);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (npcs_op_t'(in_tuser) == OP_QUERY) begin
            cmd.start = 1'b1;
            addr_nxt  = '0;
            state_nxt = ST_SCAN;
          end else begin
            // the last entry stays black
            cmd.load_we = (entry_index < 8'(PAL_ENTRIES - 1));
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        addr_nxt  = addr_r + PAL_IDX_W'(1);
        if (addr_r == PAL_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.last_done) begin
          state_nxt = ST_PUB;
        end
      end
      ST_PUB: begin
        if (!out_valid_r || out_tready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `NPCS_ASSERT_IMP(a_issue_blocks_in, cmd.issue, !in_tready, "intake open during scan")
  `NPCS_ASSERT_IMP(a_last_in_drain, stat.last_done, state_r == ST_DRAIN,
                   "scan finished outside drain")
  `NPCS_ASSERT_IMP(a_no_overwrite, cmd.publish, !out_valid_r || out_tready,
                   "pending result overwritten")
  `NPCS_ASSERT_NXT(a_publish_valid, cmd.publish, out_valid_r, "published result not valid")

endmodule

`default_nettype wire

/* sv/nearest_palette_color_search_unit.sv */
// Nearest palette colour search: holds a 256-entry RGB palette (cleared to
// black at reset, last entry fixed at black) and answers RGB555 queries with
// the index of the closest entry by squared distance, first minimum winning.
// A load returns nothing. A query reads every palette entry in turn: the
// single read port of the palette RAM delivers one entry per cycle, followed
// by a two-stage distance pipeline and the best tracker; the result then
// moves into the output register once any earlier result there is taken.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is taken. Depends on npcs_pkg, npcs_ctrl,
// npcs_dp and npcs_ram.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_search_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue,
  // [46:32] color_in, [47] zero
  input  wire logic [47:0] in_tdata,
  // [0] opcode (0 load, 1 query)
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] nearest_index, [25:8] best_distance_sq, [31:26] zero
  output logic      [31:0] out_tdata
);
  import npcs_pkg::*;

  npcs_cmd_t         cmd;
  npcs_stat_t        stat;
  logic [7:0]        nearest_index;
  logic [DIST_W-1:0] best_distance_sq;

  npcs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .entry_index (in_tdata[7:0]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .stat        (stat)
  );

  npcs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .entry_index      (in_tdata[7:0]),
    .red              (in_tdata[15:8]),
    .green            (in_tdata[23:16]),
    .blue             (in_tdata[31:24]),
    .color_in         (in_tdata[46:32]),
    .nearest_index    (nearest_index),
    .best_distance_sq (best_distance_sq)
  );

  assign out_tdata = {6'b0, best_distance_sq, nearest_index};

endmodule

`default_nettype wire
